@@ hdl/load_rate_led_blinker_assert.svh @@
// assertion helpers for the load-rate led blinker
`ifndef LOAD_RATE_LED_BLINKER_ASSERT_SVH
`define LOAD_RATE_LED_BLINKER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LLB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/llb_pkg.sv @@
`default_nettype none

package llb_pkg;

  localparam int unsigned CntInW     = 32;
  localparam int unsigned ShareW     = 7;
  localparam int unsigned OutPeriodW = 24;
  localparam int unsigned CfgDataW   = 24;
  localparam int unsigned CfgIdxW    = 2;

  localparam int unsigned Percent        = 100;
  localparam int unsigned MinPeriodReset = 100000;
  localparam int unsigned MaxPeriodReset = 1000000;

  localparam logic [CfgIdxW-1:0] CfgMinPeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxPeriod = 2'd1;

  localparam logic CmdTick   = 1'b0;
  localparam logic CmdSample = 1'b1;

  typedef struct packed {
    logic              command;
    logic [CntInW-1:0] user_time;
    logic [CntInW-1:0] nice_time;
    logic [CntInW-1:0] system_time;
    logic [CntInW-1:0] idle_time;
  } in_item_t;

  typedef struct packed {
    logic                  led_on;
    logic                  toggled;
    logic [ShareW-1:0]     idle_share;
    logic [OutPeriodW-1:0] blink_period;
  } out_item_t;

endpackage

`default_nettype wire

@@ hdl/llb_in_if.sv @@
`default_nettype none

interface llb_in_if;
  logic             valid;
  logic             ready;
  llb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/llb_out_if.sv @@
`default_nettype none

interface llb_out_if;
  logic              valid;
  logic              ready;
  llb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/load_rate_led_blinker.sv @@
// Load-rate LED blinker.
// sample_i takes one item per transaction: command 0 is one time tick,
// command 1 is a load sample with four cumulative time counters.
// result_o gives exactly one result per accepted item: LED drive, toggle
// flag, idle percentage of the latest sample and the period in force.
// cfg_we_i/cfg_idx_i/cfg_data_i write min_period (0) and max_period (1);
// write them only while the block is idle.
// A tick is handled in the accept cycle; its result is valid the next cycle.
// A sample runs on one shared add/subtract unit under a sequencer: three
// sums, two differences, a compare, a setup step and 7 steps of the share
// division, the span, its product with the share, a reciprocal multiply for
// the divide by 100 and three period updates; an unchanged total goes from
// the first difference to the span, and a saturated share from the compare.
// Samples wait for the last one to finish; ticks one per cycle unless stalled.
// sample_i.ready is low while a sample is in work and while the output
// register holds a result the receiver has not taken; a stalled receiver
// simply holds the result and no item is lost.
// Reset clears the counters, sets period and time left to 1000000, turns
// the LED off and restores the register defaults.
`default_nettype none

module load_rate_led_blinker #(
  parameter int PERIOD_BITS  = 24,
  parameter int COUNTER_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [llb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [llb_pkg::CfgDataW-1:0]  cfg_data_i,
  llb_in_if.sink                        sample_i,
  llb_out_if.source                     result_o
);
  import llb_pkg::*;

  `include "load_rate_led_blinker_assert.svh"

  localparam int PW   = PERIOD_BITS;
  localparam int CW   = COUNTER_BITS;
  localparam int AW   = ((CW > PW + 1) ? CW : PW + 1) + 1;
  localparam int CntW = $clog2(ShareW + 1);
  localparam int XW   = PW + 7;

  // floor(x / 100) for x below 2^XW as a multiply by the rounded-up reciprocal
  localparam int              RecipShift = XW + 7;
  localparam longint unsigned RecipFull  =
    ((64'd1 << RecipShift) + 64'(Percent) - 64'd1) / 64'(Percent);
  localparam logic [XW:0]     Recip100   = (XW + 1)'(RecipFull);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SUM1   = 4'd1;
  localparam logic [3:0] ST_SUM2   = 4'd2;
  localparam logic [3:0] ST_SUM3   = 4'd3;
  localparam logic [3:0] ST_DT     = 4'd4;
  localparam logic [3:0] ST_DI     = 4'd5;
  localparam logic [3:0] ST_CMP    = 4'd6;
  localparam logic [3:0] ST_MUL100 = 4'd7;
  localparam logic [3:0] ST_DIV    = 4'd8;
  localparam logic [3:0] ST_SPAN   = 4'd9;
  localparam logic [3:0] ST_MUL    = 4'd10;
  localparam logic [3:0] ST_DIV100 = 4'd11;
  localparam logic [3:0] ST_ADDMIN = 4'd12;
  localparam logic [3:0] ST_T1     = 4'd13;
  localparam logic [3:0] ST_T2     = 4'd14;

  // control and model state
  logic [3:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PW-1:0]     min_period_q, min_period_d;
  logic [PW-1:0]     max_period_q, max_period_d;
  logic [CW-1:0]     prev_idle_q, prev_idle_d;
  logic [CW-1:0]     prev_total_q, prev_total_d;
  logic [PW-1:0]     period_now_q, period_now_d;
  logic [PW-1:0]     ticks_left_q, ticks_left_d;
  logic              led_q, led_d;
  logic [ShareW-1:0] last_share_q, last_share_d;
  logic              out_valid_q, out_valid_d;

  // working payload
  logic [CW-1:0]     user_q, user_d;
  logic [CW-1:0]     nice_q, nice_d;
  logic [CW-1:0]     sys_q, sys_d;
  logic [CW-1:0]     idle_q, idle_d;
  logic [CW-1:0]     acc_q, acc_d;
  logic [CW-1:0]     dt_q, dt_d;
  logic [CW-1:0]     di_q, di_d;
  logic [AW-1:0]     r_q, r_d;
  logic [PW-1:0]     sh_q, sh_d;
  logic [PW-1:0]     quo_q, quo_d;
  logic [ShareW-1:0] pct_q, pct_d;
  logic [PW-1:0]     span_q, span_d;
  logic [XW-1:0]     prod_q, prod_d;
  logic [PW-1:0]     newp_q, newp_d;
  out_item_t         out_q, out_d;

  // shared add/subtract unit
  logic [AW-1:0]     u_a, u_b;
  logic              u_sub;
  logic [AW:0]       u_res;
  logic              u_carry;

  logic              in_ready;
  logic              in_take;
  logic [CW+6:0]     n100;
  logic [PW+6:0]     xprod;
  logic [2*XW:0]     qprod;
  logic [PW-1:0]     quo_next;

  assign in_ready       = (state_q == ST_IDLE) && (!out_valid_q || result_o.ready);
  assign in_take        = sample_i.valid && in_ready;
  assign sample_i.ready = in_ready;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  assign n100  = ({7'd0, di_q} << 6) + ({7'd0, di_q} << 5) + ({7'd0, di_q} << 2);
  assign xprod = (PW + 7)'(span_q) * (PW + 7)'(pct_q);
  assign qprod = (2 * XW + 1)'(prod_q) * (2 * XW + 1)'(Recip100);

  always_comb begin
    u_a   = '0;
    u_b   = '0;
    u_sub = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        u_a   = AW'(ticks_left_q);
        u_b   = AW'(1);
        u_sub = 1'b1;
      end
      ST_SUM1: begin
        u_a = AW'(user_q);
        u_b = AW'(nice_q);
      end
      ST_SUM2: begin
        u_a = AW'(acc_q);
        u_b = AW'(sys_q);
      end
      ST_SUM3: begin
        u_a = AW'(acc_q);
        u_b = AW'(idle_q);
      end
      ST_DT: begin
        u_a   = AW'(acc_q);
        u_b   = AW'(prev_total_q);
        u_sub = 1'b1;
      end
      ST_DI: begin
        u_a   = AW'(idle_q);
        u_b   = AW'(prev_idle_q);
        u_sub = 1'b1;
      end
      ST_CMP: begin
        u_a   = AW'(di_q);
        u_b   = AW'(dt_q);
        u_sub = 1'b1;
      end
      ST_DIV: begin
        u_a   = {r_q[AW-2:0], sh_q[PW-1]};
        u_b   = AW'(dt_q);
        u_sub = 1'b1;
      end
      ST_SPAN: begin
        u_a   = AW'(max_period_q);
        u_b   = AW'(min_period_q);
        u_sub = 1'b1;
      end
      ST_ADDMIN: begin
        u_a = AW'(min_period_q);
        u_b = AW'(quo_q);
      end
      ST_T1: begin
        u_a = AW'(ticks_left_q);
        u_b = AW'(newp_q);
      end
      ST_T2: begin
        u_a   = r_q;
        u_b   = AW'(period_now_q);
        u_sub = 1'b1;
      end
      default: begin
        u_a = '0;
      end
    endcase
  end

  assign u_res    = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + {{AW{1'b0}}, u_sub};
  assign u_carry  = u_res[AW];
  assign quo_next = {quo_q[PW-2:0], u_carry};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    min_period_d = min_period_q;
    max_period_d = max_period_q;
    prev_idle_d  = prev_idle_q;
    prev_total_d = prev_total_q;
    period_now_d = period_now_q;
    ticks_left_d = ticks_left_q;
    led_d        = led_q;
    last_share_d = last_share_q;
    out_valid_d  = out_valid_q;
    user_d       = user_q;
    nice_d       = nice_q;
    sys_d        = sys_q;
    idle_d       = idle_q;
    acc_d        = acc_q;
    dt_d         = dt_q;
    di_d         = di_q;
    r_d          = r_q;
    sh_d         = sh_q;
    quo_d        = quo_q;
    pct_d        = pct_q;
    span_d       = span_q;
    prod_d       = prod_q;
    newp_d       = newp_q;
    out_d        = out_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinPeriod: min_period_d = PW'(cfg_data_i);
        CfgMaxPeriod: max_period_d = PW'(cfg_data_i);
        default: ;
      endcase
    end

    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if (sample_i.data.command == CmdSample) begin
            user_d  = CW'(sample_i.data.user_time);
            nice_d  = CW'(sample_i.data.nice_time);
            sys_d   = CW'(sample_i.data.system_time);
            idle_d  = CW'(sample_i.data.idle_time);
            state_d = ST_SUM1;
          end else begin
            out_d.toggled = 1'b0;
            out_d.led_on  = led_q;
            // time left 0 or 1 toggles and reloads
            if (|ticks_left_q[PW-1:1]) begin
              ticks_left_d = u_res[PW-1:0];
            end else begin
              led_d         = ~led_q;
              ticks_left_d  = period_now_q;
              out_d.toggled = 1'b1;
              out_d.led_on  = ~led_q;
            end
            out_d.idle_share   = last_share_q;
            out_d.blink_period = OutPeriodW'(period_now_q);
            out_valid_d        = 1'b1;
          end
        end
      end
      ST_SUM1: begin
        acc_d   = u_res[CW-1:0];
        state_d = ST_SUM2;
      end
      ST_SUM2: begin
        acc_d   = u_res[CW-1:0];
        state_d = ST_SUM3;
      end
      ST_SUM3: begin
        acc_d   = u_res[CW-1:0];
        state_d = ST_DT;
      end
      ST_DT: begin
        dt_d = u_res[CW-1:0];
        // unchanged total keeps the stored counters
        if (u_res[CW-1:0] == '0) begin
          pct_d   = '0;
          state_d = ST_SPAN;
        end else begin
          state_d = ST_DI;
        end
      end
      ST_DI: begin
        di_d         = u_res[CW-1:0];
        prev_idle_d  = idle_q;
        prev_total_d = acc_q;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        if (u_carry) begin
          pct_d   = ShareW'(Percent);
          state_d = ST_SPAN;
        end else begin
          state_d = ST_MUL100;
        end
      end
      ST_MUL100: begin
        // quotient is below 100, so seven steps past the top bits
        r_d     = AW'(n100[CW+6:7]);
        sh_d    = {n100[6:0], {(PW - 7){1'b0}}};
        quo_d   = '0;
        cnt_d   = CntW'(7);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        r_d   = u_carry ? u_res[AW-1:0] : u_a;
        sh_d  = {sh_q[PW-2:0], 1'b0};
        quo_d = quo_next;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          pct_d   = quo_next[ShareW-1:0];
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        span_d  = u_carry ? u_res[PW-1:0] : '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = xprod;
        state_d = ST_DIV100;
      end
      ST_DIV100: begin
        quo_d   = qprod[RecipShift +: PW];
        state_d = ST_ADDMIN;
      end
      ST_ADDMIN: begin
        newp_d  = u_res[PW-1:0];
        state_d = ST_T1;
      end
      ST_T1: begin
        r_d     = u_res[AW-1:0];
        state_d = ST_T2;
      end
      ST_T2: begin
        // clamp at zero below, saturate at the period width above
        if (!u_carry) begin
          ticks_left_d = '0;
        end else if (u_res[AW-1:PW] != '0) begin
          ticks_left_d = '1;
        end else begin
          ticks_left_d = u_res[PW-1:0];
        end
        period_now_d       = newp_q;
        last_share_d       = pct_q;
        out_d.led_on       = led_q;
        out_d.toggled      = 1'b0;
        out_d.idle_share   = pct_q;
        out_d.blink_period = OutPeriodW'(newp_q);
        out_valid_d        = 1'b1;
        state_d            = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      min_period_q <= PW'(MinPeriodReset);
      max_period_q <= PW'(MaxPeriodReset);
      prev_idle_q  <= '0;
      prev_total_q <= '0;
      period_now_q <= PW'(MaxPeriodReset);
      ticks_left_q <= PW'(MaxPeriodReset);
      led_q        <= 1'b0;
      last_share_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      min_period_q <= min_period_d;
      max_period_q <= max_period_d;
      prev_idle_q  <= prev_idle_d;
      prev_total_q <= prev_total_d;
      period_now_q <= period_now_d;
      ticks_left_q <= ticks_left_d;
      led_q        <= led_d;
      last_share_q <= last_share_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    user_q <= user_d;
    nice_q <= nice_d;
    sys_q  <= sys_d;
    idle_q <= idle_d;
    acc_q  <= acc_d;
    dt_q   <= dt_d;
    di_q   <= di_d;
    r_q    <= r_d;
    sh_q   <= sh_d;
    quo_q  <= quo_d;
    pct_q  <= pct_d;
    span_q <= span_d;
    prod_q <= prod_d;
    newp_q <= newp_d;
    out_q  <= out_d;
  end

  // a sample transaction starts the sequencer
  `LLB_ASSERT_NEXT(a_sample_starts, in_take && (sample_i.data.command == CmdSample), state_q == ST_SUM1, "sample did not start the sequencer")
  // the output register stays free while a sample is in work
  `LLB_ASSERT_NOW(a_out_free_busy, state_q != ST_IDLE, !out_valid_q, "result pending during sample work")
  // the last step always delivers a result
  `LLB_ASSERT_NEXT(a_done_delivers, state_q == ST_T2, out_valid_q && (state_q == ST_IDLE), "sample finished without a result")
  // the iteration counter never runs out during the share division
  `LLB_ASSERT_NOW(a_div_count, state_q == ST_DIV, cnt_q != '0, "divide step with empty counter")

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

  import llb_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare3 = 2'd3;
  localparam logic [OutPeriodW-1:0] PeriodMax = {OutPeriodW{1'b1}};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  llb_in_if  in_if ();
  llb_out_if out_if ();

  load_rate_led_blinker i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (in_if),
    .result_o   (out_if)
  );

  always #1 clk_i = ~clk_i;

  // items waiting to be offered, and the led results they must produce
  in_item_t  item_q[$];
  out_item_t led_expect_q[$];

  // predictor state
  logic [OutPeriodW-1:0] reg_min;
  logic [OutPeriodW-1:0] reg_max;
  logic [CntInW-1:0]     last_idle_cnt  = '0;
  logic [CntInW-1:0]     last_total_cnt = '0;
  logic [OutPeriodW-1:0] cur_period     = OutPeriodW'(MaxPeriodReset);
  logic [OutPeriodW-1:0] time_to_flip   = OutPeriodW'(MaxPeriodReset);
  logic                  led_lit        = 1'b0;
  logic [ShareW-1:0]     cur_share      = '0;

  // host-side cumulative counters for well-formed samples
  logic [CntInW-1:0] host_user;
  logic [CntInW-1:0] host_nice;
  logic [CntInW-1:0] host_sys;
  logic [CntInW-1:0] host_idle;

  int unsigned err_cnt = 0;
  int unsigned report_cnt = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned taken_cnt = 0;
  int unsigned hold_left = 0;
  int unsigned hold_at = 150;
  int unsigned mode_left = 0;
  int unsigned rx_mode = 0;
  out_item_t   want_item;

  function automatic out_item_t led_after(in_item_t it);
    out_item_t             res;
    logic [CntInW-1:0]     total;
    logic [CntInW-1:0]     d_total;
    logic [CntInW-1:0]     d_idle;
    logic [63:0]           pct;
    logic [OutPeriodW-1:0] top;
    logic [OutPeriodW-1:0] span;
    logic [OutPeriodW-1:0] next_p;
    longint                left;
    logic                  flip;
    flip = 1'b0;
    if (it.command == CmdSample) begin
      total = it.user_time + it.nice_time + it.system_time + it.idle_time;
      pct = '0;
      // no time passed: keep the old counters, report zero idle
      if (total != last_total_cnt) begin
        d_total = total - last_total_cnt;
        d_idle  = it.idle_time - last_idle_cnt;
        if (d_idle >= d_total) begin
          pct = 64'(Percent);
        end else begin
          pct = (64'(d_idle) * 64'(Percent)) / 64'(d_total);
        end
        last_idle_cnt  = it.idle_time;
        last_total_cnt = total;
      end
      cur_share = pct[ShareW-1:0];
      top = (reg_max < reg_min) ? reg_min : reg_max;
      span = top - reg_min;
      next_p = OutPeriodW'(64'(reg_min) + (64'(span) * pct) / 64'(Percent));
      left = longint'(time_to_flip) - longint'(cur_period) + longint'(next_p);
      if (left < 0) left = 0;
      if (left > longint'(PeriodMax)) begin
        time_to_flip = PeriodMax;
      end else begin
        time_to_flip = OutPeriodW'(left);
      end
      cur_period = next_p;
    end else begin
      if (time_to_flip > 1) begin
        time_to_flip = time_to_flip - 1'b1;
      end else begin
        led_lit = ~led_lit;
        flip = 1'b1;
        time_to_flip = cur_period;
      end
    end
    res.led_on       = led_lit;
    res.toggled      = flip;
    res.idle_share   = cur_share;
    res.blink_period = cur_period;
    return res;
  endfunction

  // driver: bursts of transactions with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        led_expect_q.push_back(led_after(in_if.data));
        void'(item_q.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 6);
            default:    gap_left = $urandom_range(7, 60);
          endcase
          burst_left = $urandom_range(1, 24);
        end
      end
      // hold a stalled transaction as it is
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (item_q.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.data  <= item_q[0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall pattern plus long hold-offs to back up the block
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) taken_cnt++;
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (hold_left == 0 && taken_cnt >= hold_at) begin
        hold_left = 300;
        hold_at   = hold_at + 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (led_expect_q.size() == 0) begin
        err_cnt++;
        if (report_cnt < 10) begin
          report_cnt++;
          $display("%0t: result with nothing expected: led %0b tog %0b share %0d period %0d",
                   $realtime, out_if.data.led_on, out_if.data.toggled,
                   out_if.data.idle_share, out_if.data.blink_period);
        end
      end else begin
        want_item = led_expect_q.pop_front();
        if (out_if.data.led_on !== want_item.led_on ||
            out_if.data.toggled !== want_item.toggled ||
            out_if.data.idle_share !== want_item.idle_share ||
            out_if.data.blink_period !== want_item.blink_period) begin
          err_cnt++;
          if (report_cnt < 10) begin
            report_cnt++;
            $display("%0t: mismatch exp led %0b tog %0b share %0d period %0d", $realtime,
                     want_item.led_on, want_item.toggled, want_item.idle_share,
                     want_item.blink_period);
            $display("%0t:          got led %0b tog %0b share %0d period %0d", $realtime,
                     out_if.data.led_on, out_if.data.toggled, out_if.data.idle_share,
                     out_if.data.blink_period);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == CfgMinPeriod) reg_min = value;
    else if (idx == CfgMaxPeriod) reg_max = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_periods(logic [CfgDataW-1:0] lo, logic [CfgDataW-1:0] hi);
    write_reg(CfgMinPeriod, lo);
    write_reg(CfgMaxPeriod, hi);
  endtask

  // wait until every transaction is out and every result is back
  task automatic drain();
    do @(posedge clk_i);
    while (item_q.size() != 0 || in_if.valid || led_expect_q.size() != 0);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic push_tick();
    in_item_t it;
    it.command     = CmdTick;
    it.user_time   = $urandom();
    it.nice_time   = $urandom();
    it.system_time = $urandom();
    it.idle_time   = $urandom();
    item_q.push_back(it);
  endtask

  task automatic push_counters(logic [CntInW-1:0] u, logic [CntInW-1:0] n,
                               logic [CntInW-1:0] s, logic [CntInW-1:0] i);
    in_item_t it;
    host_user = u;
    host_nice = n;
    host_sys  = s;
    host_idle = i;
    it.command     = CmdSample;
    it.user_time   = u;
    it.nice_time   = n;
    it.system_time = s;
    it.idle_time   = i;
    item_q.push_back(it);
  endtask

  task automatic push_delta(logic [CntInW-1:0] du, logic [CntInW-1:0] dn,
                            logic [CntInW-1:0] ds, logic [CntInW-1:0] di);
    push_counters(host_user + du, host_nice + dn, host_sys + ds, host_idle + di);
  endtask

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CfgMinPeriod;
    cfg_data_i   = '0;

    reg_min        = OutPeriodW'(MinPeriodReset);
    reg_max        = OutPeriodW'(MaxPeriodReset);
    host_user      = '0;
    host_nice      = '0;
    host_sys       = '0;
    host_idle      = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: unchanged total from zero, then all counters at max
    @(negedge clk_i);
    push_counters('0, '0, '0, '0);
    push_tick();
    push_counters('1, '1, '1, '1);
    push_tick();
    drain();

    set_periods(24'd2, 24'd12);
    write_reg(CfgIdxSpare3, '1);
    write_reg(CfgIdxSpare2, 24'h5a5a5a);
    @(negedge clk_i);
    push_delta(32'd50, 32'd0, 32'd0, 32'd50);      // counters wrap here
    push_delta(32'd0, 32'd0, 32'd0, 32'd0);
    push_delta(32'd10, 32'd0, 32'd0, 32'd0);
    push_delta(32'd0, 32'd0, 32'd0, 32'd7);
    push_delta(-32'sd5, 32'd0, 32'd0, 32'd10);     // idle step above total step
    push_delta(32'd1, 32'd1, 32'd1, 32'd0);
    push_delta(32'd2, 32'd0, 32'd0, 32'd1);
    repeat (8) push_tick();
    push_delta(32'd0, 32'd0, 32'd0, 32'd9);
    repeat (6) push_tick();
    push_delta(32'd3, 32'd0, 32'd0, 32'd0);        // time left goes below zero
    repeat (3) push_tick();
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       set_periods(24'd1, PeriodMax);
        1:       set_periods(PeriodMax, PeriodMax);
        2:       set_periods(PeriodMax, 24'd1);
        3:       set_periods(24'd1, 24'd1);
        default: set_periods(CfgDataW'($urandom_range(1, 6)),
                             CfgDataW'($urandom_range(1, 40)));
      endcase
      write_reg(CfgIdxSpare3, CfgDataW'($urandom()));
      @(negedge clk_i);
      for (int k = 0; k < 140; k++) begin
        case ($urandom_range(0, 99)) inside
          [0:59]: push_tick();
          [60:87]: begin
            if ($urandom_range(0, 19) == 0) begin
              push_delta($urandom(), $urandom(), $urandom(), $urandom());
            end else begin
              push_delta($urandom_range(0, 300), $urandom_range(0, 20),
                         $urandom_range(0, 200), $urandom_range(0, 500));
            end
          end
          [88:94]: push_counters($urandom(), $urandom(), $urandom(), $urandom());
          default: begin
            if ($urandom_range(0, 1) == 0) begin
              push_delta('0, '0, '0, '0);
            end else begin
              push_delta($urandom_range(1, 100), $urandom_range(0, 10),
                         $urandom_range(0, 100), -$urandom_range(1, 100));
            end
          end
        endcase
      end
      drain();
    end

    if (err_cnt == 0 && led_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ load_rate_led_blinker.f @@
+incdir+hdl
hdl/llb_pkg.sv
hdl/llb_in_if.sv
hdl/llb_out_if.sv
hdl/load_rate_led_blinker.sv
test/tb.sv
